@@ rtl/core/speck128_128_block_cipher_defines.svh @@
// Assertion macros for the Speck128/128 core.
// Used by the top level; assumes signals clk and rst_n in scope.
`ifndef SPECK128_128_BLOCK_CIPHER_DEFINES_SVH
`define SPECK128_128_BLOCK_CIPHER_DEFINES_SVH

// condition must never hold at a clock edge
`define SPK_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

// consequent holds in the same cycle as the antecedent
`define SPK_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// consequent holds in the cycle after the antecedent
`define SPK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ rtl/core/spk_pkg.sv @@
// Shared types, codes and round functions of the Speck128/128 core.
// No dependencies.
`default_nettype none

package spk_pkg;

    localparam int WORD_W      = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int ROT_X       = 8;
    localparam int ROT_Y       = 3;

    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_KEY_WORD0 = 2'd0;
    localparam cfg_index_t REG_KEY_WORD1 = 2'd1;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef struct packed {
        word_t x;
        word_t y;
    } halves_t;

    function automatic word_t rotr(word_t v, int s);
        return (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic word_t rotl(word_t v, int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic halves_t speck_fwd(halves_t s, word_t k);
        halves_t r;
        r.x = (rotr(s.x, ROT_X) + s.y) ^ k;
        r.y = rotl(s.y, ROT_Y) ^ r.x;
        return r;
    endfunction

    function automatic halves_t speck_inv(halves_t s, word_t k);
        halves_t r;
        r.y = rotr(s.y ^ s.x, ROT_Y);
        r.x = rotl((s.x ^ k) - r.y, ROT_X);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/speck128_128_block_cipher.sv @@
// Speck128/128 block cipher core: key schedule and round engine on a key RAM.
// Depends on spk_pkg, spk_ram and speck128_128_block_cipher_defines.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------
//  input    | in_valid/in_stall  | kind, block_word0, block_word1
//  output   | out_valid/out_stall| out_word0, out_word1
//  config   | wr_en              | wr_index, wr_data
//
// One round per cycle, one round key read from the key RAM per cycle while a
// block runs; a new block is accepted only once the engine is idle again.
// A key word write restarts the schedule, which rewrites every key RAM entry;
// in_stall is high meanwhile. Reset clears key words and control; the key RAM
// holds nothing valid until a key word is written.
// A finished block waits in the output register; a stalled output holds the
// engine once it has a second result ready.
`default_nettype none
`include "speck128_128_block_cipher_defines.svh"

module speck128_128_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  spk_pkg::word_t      block_word0,
    input  spk_pkg::word_t      block_word1,
    output logic                out_valid,
    input  logic                out_stall,
    output spk_pkg::word_t      out_word0,
    output spk_pkg::word_t      out_word1,
    input  logic                wr_en,
    input  spk_pkg::cfg_index_t wr_index,
    input  spk_pkg::word_t      wr_data
);

    import spk_pkg::*;

    localparam int          RW   = $clog2(ROUNDS);
    localparam logic [RW-1:0] LAST = RW'(ROUNDS - 1);

    localparam logic [1:0] ENG_IDLE = 2'd0;
    localparam logic [1:0] ENG_RUN  = 2'd1;
    localparam logic [1:0] ENG_HOLD = 2'd2;

    // key words and schedule
    word_t         key0_reg, key0_next;
    word_t         key1_reg, key1_next;
    logic          exp_active_reg, exp_active_next;
    logic [RW-1:0] exp_cnt_reg, exp_cnt_next;
    halves_t       sched_reg, sched_next;   // x = b, y = a
    halves_t       sched_step;

    // round engine
    logic [1:0]    eng_state_reg, eng_state_next;
    logic [RW-1:0] cnt_reg, cnt_next;
    halves_t       st_reg, st_next;
    halves_t       round_res;
    logic          kind_reg, kind_next;
    halves_t       out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          in_accept;
    logic          out_space;
    logic          key_write;
    logic [RW-1:0] rd_round;
    logic [RW-1:0] rd_addr;
    logic          rd_kind;
    word_t         round_key;

    spk_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ROUNDS)
    ) u_key_ram (
        .clk    (clk),
        .wr_en  (exp_active_reg),
        .wr_addr(exp_cnt_reg),
        .wr_data(sched_reg.y),
        .rd_addr(rd_addr),
        .rd_data(round_key)
    );

    assign key_write = wr_en && (wr_index == REG_KEY_WORD0 || wr_index == REG_KEY_WORD1);
    // no block enters while the key RAM is being rewritten
    assign in_stall  = exp_active_reg || wr_en || (eng_state_reg != ENG_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_space = !out_valid_reg || !out_stall;

    assign sched_step = speck_fwd(sched_reg, WORD_W'(exp_cnt_reg));

    // key schedule
    always_comb
    begin
        key0_next       = key0_reg;
        key1_next       = key1_reg;
        exp_active_next = exp_active_reg;
        exp_cnt_next    = exp_cnt_reg;
        sched_next      = sched_reg;
        if (key_write)
        begin
            if (wr_index == REG_KEY_WORD0)
            begin
                key0_next = wr_data;
            end
            else
            begin
                key1_next = wr_data;
            end
            exp_active_next = 1'b1;
            exp_cnt_next    = '0;
            sched_next.y    = key0_next;
            sched_next.x    = key1_next;
        end
        else if (exp_active_reg)
        begin
            sched_next   = sched_step;
            exp_cnt_next = exp_cnt_reg + 1'b1;
            if (exp_cnt_reg == LAST)
            begin
                exp_active_next = 1'b0;
            end
        end
    end

    // key for the next round cycle; decrypt walks the keys backward
    always_comb
    begin
        if (eng_state_reg == ENG_RUN)
        begin
            rd_round = cnt_reg + 1'b1;
            rd_kind  = kind_reg;
        end
        else
        begin
            rd_round = '0;
            rd_kind  = kind;
        end
        rd_addr = (rd_kind == KIND_DECRYPT) ? (LAST - rd_round) : rd_round;
    end

    assign round_res = (kind_reg == KIND_DECRYPT) ? speck_inv(st_reg, round_key)
                                                  : speck_fwd(st_reg, round_key);

    // round engine and output register
    always_comb
    begin
        eng_state_next = eng_state_reg;
        cnt_next       = cnt_reg;
        st_next        = st_reg;
        kind_next      = kind_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (eng_state_reg)
            ENG_IDLE:
            begin
                if (in_accept)
                begin
                    st_next.x      = block_word1;
                    st_next.y      = block_word0;
                    kind_next      = kind;
                    cnt_next       = '0;
                    eng_state_next = ENG_RUN;
                end
            end
            ENG_RUN:
            begin
                st_next  = round_res;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    if (out_space)
                    begin
                        out_next       = round_res;
                        out_valid_next = 1'b1;
                        eng_state_next = ENG_IDLE;
                    end
                    else
                    begin
                        eng_state_next = ENG_HOLD;
                    end
                end
            end
            ENG_HOLD:
            begin
                if (out_space)
                begin
                    out_next       = st_reg;
                    out_valid_next = 1'b1;
                    eng_state_next = ENG_IDLE;
                end
            end
            default:
            begin
                eng_state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg       <= '0;
            key1_reg       <= '0;
            exp_active_reg <= 1'b0;
            exp_cnt_reg    <= '0;
            eng_state_reg  <= ENG_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            key0_reg       <= key0_next;
            key1_reg       <= key1_next;
            exp_active_reg <= exp_active_next;
            exp_cnt_reg    <= exp_cnt_next;
            eng_state_reg  <= eng_state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        st_reg    <= st_next;
        kind_reg  <= kind_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word0 = out_reg.y;
    assign out_word1 = out_reg.x;

    `SPK_ASSERT_NEVER(a_no_accept_in_schedule, in_valid && !in_stall && exp_active_reg)
    `SPK_ASSERT_NEXT(a_accept_starts_run, in_valid && !in_stall, eng_state_reg == ENG_RUN)
    `SPK_ASSERT_IMPL(a_hold_needs_full_out, eng_state_reg == ENG_HOLD, out_valid_reg)

endmodule

`default_nettype wire

@@ rtl/core/spk_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module spk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
